FILE: hdl/uer4_pkg.sv
package uer4_pkg;

   // sensors actually ranged in a round (1..4); the ports always carry four
   localparam int NumSensors = 4;
   // echo ticks per centimeter (58 us round trip per cm)
   localparam int CmDivisor = 58;
   localparam logic [9:0] DistMax = 10'd1023;

   localparam logic [7:0]  TriggerTicksReset = 8'd10;
   localparam logic [14:0] TimeoutTicksReset = 15'd23000;
   localparam logic [15:0] SettleTicksReset  = 16'd10000;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_TRIG   = 5'b00010,
      PH_RISE   = 5'b00100,
      PH_FALL   = 5'b01000,
      PH_SETTLE = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      REG_TRIGGER = 2'd0,
      REG_TIMEOUT = 2'd1,
      REG_SETTLE  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [7:0]  trigger_ticks;
      logic [14:0] timeout_ticks;
      logic [15:0] settle_ticks;
   } cfg_type;

   typedef struct packed {
      logic [3:0]       trigger_pins;
      logic [3:0][9:0]  distances;
      logic             round_done;
      logic             busy_res;
   } rsp_type;

endpackage

FILE: hdl/uer4_csr.sv
module uer4_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output uer4_pkg::cfg_type    cfg
);

   uer4_pkg::cfg_type       cfg_ff;
   uer4_pkg::cfg_type       cfg_in;
   uer4_pkg::reg_index_type reg_sel;
   logic                    wr_en;

   assign reg_sel    = uer4_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in     = cfg_ff;
      csr_prdata = 32'd0;
      unique case (reg_sel)
         uer4_pkg::REG_TRIGGER: begin
            csr_prdata = {24'd0, cfg_ff.trigger_ticks};
            if (wr_en) cfg_in.trigger_ticks = csr_pwdata[7:0];
         end
         uer4_pkg::REG_TIMEOUT: begin
            csr_prdata = {17'd0, cfg_ff.timeout_ticks};
            if (wr_en) cfg_in.timeout_ticks = csr_pwdata[14:0];
         end
         uer4_pkg::REG_SETTLE: begin
            csr_prdata = {16'd0, cfg_ff.settle_ticks};
            if (wr_en) cfg_in.settle_ticks = csr_pwdata[15:0];
         end
         default: begin
            csr_prdata = 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_ticks <= uer4_pkg::TriggerTicksReset;
         cfg_ff.timeout_ticks <= uer4_pkg::TimeoutTicksReset;
         cfg_ff.settle_ticks  <= uer4_pkg::SettleTicksReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/uer4_core.sv
module uer4_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 start_round,
   input  logic [3:0]           echo_levels,
   input  uer4_pkg::cfg_type    cfg,
   output uer4_pkg::rsp_type    rsp
);

   uer4_pkg::phase_type phase_ff, phase_in;
   logic [1:0]          sensor_index_ff, sensor_index_in;
   logic [15:0]         tick_count_ff, tick_count_in;
   logic [5:0]          sub_count_ff, sub_count_in;
   logic [9:0]          distance_accum_ff, distance_accum_in;
   logic                prev_echo_ff, prev_echo_in;
   logic [3:0][9:0]     distances_ff, distances_in;

   logic                echo;
   logic [15:0]         tick_inc;
   logic [5:0]          sub_inc;
   logic                last_sensor;
   logic                finished;
   logic                timed_out;
   logic                advance;
   logic                done;

   assign echo        = echo_levels[sensor_index_ff];
   assign tick_inc    = tick_count_ff + 16'd1;
   assign sub_inc     = sub_count_ff + 6'd1;
   assign last_sensor = ({1'b0, sensor_index_ff} + 3'd1) >= 3'(uer4_pkg::NumSensors);

   always_comb begin
      phase_in          = phase_ff;
      sensor_index_in   = sensor_index_ff;
      tick_count_in     = tick_count_ff;
      sub_count_in      = sub_count_ff;
      distance_accum_in = distance_accum_ff;
      prev_echo_in      = prev_echo_ff;
      distances_in      = distances_ff;
      finished          = 1'b0;
      timed_out         = 1'b0;
      advance           = 1'b0;
      done              = 1'b0;

      unique case (phase_ff)
         uer4_pkg::PH_IDLE: begin
            if (start_round) begin
               phase_in        = uer4_pkg::PH_TRIG;
               sensor_index_in = 2'd0;
               tick_count_in   = 16'd0;
            end
         end
         uer4_pkg::PH_TRIG: begin
            // sample echo here so a level already high is not taken as an edge
            prev_echo_in  = echo;
            tick_count_in = tick_inc;
            if (tick_inc >= {8'd0, cfg.trigger_ticks}) begin
               phase_in      = uer4_pkg::PH_RISE;
               tick_count_in = 16'd0;
            end
         end
         uer4_pkg::PH_RISE: begin
            tick_count_in = tick_inc;
            prev_echo_in  = echo;
            if (echo && !prev_echo_ff) begin
               phase_in          = uer4_pkg::PH_FALL;
               distance_accum_in = 10'd0;
               sub_count_in      = 6'd1;
            end
            timed_out = tick_inc >= {1'b0, cfg.timeout_ticks};
         end
         uer4_pkg::PH_FALL: begin
            tick_count_in = tick_inc;
            prev_echo_in  = echo;
            if (echo) begin
               if (sub_inc >= 6'(uer4_pkg::CmDivisor)) begin
                  sub_count_in = 6'd0;
                  if (distance_accum_ff < uer4_pkg::DistMax)
                     distance_accum_in = distance_accum_ff + 10'd1;
               end else begin
                  sub_count_in = sub_inc;
               end
            end else begin
               distances_in[sensor_index_ff] = distance_accum_ff;
               finished = 1'b1;
               if (cfg.settle_ticks == 16'd0) begin
                  advance = 1'b1;
               end else begin
                  phase_in      = uer4_pkg::PH_SETTLE;
                  tick_count_in = 16'd0;
               end
            end
            // falling edge on the last allowed tick still counts
            timed_out = !finished && (tick_inc >= {1'b0, cfg.timeout_ticks});
         end
         uer4_pkg::PH_SETTLE: begin
            tick_count_in = tick_inc;
            if (tick_inc >= cfg.settle_ticks) advance = 1'b1;
         end
         default: begin
            phase_in        = uer4_pkg::PH_IDLE;
            sensor_index_in = 2'd0;
            tick_count_in   = 16'd0;
         end
      endcase

      if (timed_out) begin
         distances_in[sensor_index_ff] = 10'd0;
         advance = 1'b1;
      end

      if (advance) begin
         tick_count_in = 16'd0;
         if (last_sensor) begin
            phase_in        = uer4_pkg::PH_IDLE;
            sensor_index_in = 2'd0;
            done            = 1'b1;
         end else begin
            phase_in        = uer4_pkg::PH_TRIG;
            sensor_index_in = sensor_index_ff + 2'd1;
         end
      end
   end

   // trigger and busy reflect the phase at the start of the tick
   always_comb begin
      rsp.trigger_pins = (phase_ff == uer4_pkg::PH_TRIG) ? (4'b0001 << sensor_index_ff) : 4'd0;
      rsp.distances    = distances_in;
      rsp.round_done   = done;
      rsp.busy_res     = phase_ff != uer4_pkg::PH_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= uer4_pkg::PH_IDLE;
         sensor_index_ff   <= 2'd0;
         tick_count_ff     <= 16'd0;
         sub_count_ff      <= 6'd0;
         distance_accum_ff <= 10'd0;
         prev_echo_ff      <= 1'b0;
         distances_ff      <= '0;
      end else if (step) begin
         phase_ff          <= phase_in;
         sensor_index_ff   <= sensor_index_in;
         tick_count_ff     <= tick_count_in;
         sub_count_ff      <= sub_count_in;
         distance_accum_ff <= distance_accum_in;
         prev_echo_ff      <= prev_echo_in;
         distances_ff      <= distances_in;
      end
   end

endmodule

FILE: hdl/ultrasonic_echo_ranger_four_channel_top.sv
// Four-channel ultrasonic echo ranger.
// req channel: one beat per 1 us tick, carrying start_round and the four echo
//   pin levels. Feed it from a free-running time base, one beat per tick.
// rsp channel: one beat per req beat, carrying trigger drive, the four stored
//   distances (cm, 0 after a timeout), round_done and busy_res.
// csr port: APB-style; 0x0 trigger_ticks, 0x4 timeout_ticks, 0x8 settle_ticks.
//   Write only while no round is running.
// Output: the rsp beat for a req beat is registered (rsp or skid register).
// Throughput: one beat per cycle while req_stall is low; each tick is one pass of
//   the phase logic between the state registers and the rsp output register.
// Stall: a two-entry output (rsp register plus skid register) keeps req open
//   for one more beat after rsp_stall rises; req_stall rises only once the
//   skid entry is full, and drops the cycle after the rsp side drains it.
// Reset: sequencer idle, distances zero, registers back to 10 / 23000 / 10000,
//   rsp_valid low.
module ultrasonic_echo_ranger_four_channel_top (
   input  logic        clock,
   input  logic        reset,
   // tick input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_start_round,
   input  logic [3:0]  req_echo_levels,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_trigger_pins,
   output logic [9:0]  rsp_distance_a,
   output logic [9:0]  rsp_distance_b,
   output logic [9:0]  rsp_distance_c,
   output logic [9:0]  rsp_distance_d,
   output logic        rsp_round_done,
   output logic        rsp_busy_res,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   uer4_pkg::cfg_type cfg;
   uer4_pkg::rsp_type result;

   // output register and skid entry
   logic              out_valid_ff, out_valid_in;
   uer4_pkg::rsp_type out_data_ff, out_data_in;
   logic              skid_valid_ff, skid_valid_in;
   uer4_pkg::rsp_type skid_data_ff, skid_data_in;

   logic              accept;
   logic              pop;

   uer4_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // state advances exactly once per accepted tick
   uer4_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .start_round (req_start_round),
      .echo_levels (req_echo_levels),
      .cfg         (cfg),
      .rsp         (result)
   );

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign pop       = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // req is stalled; drain skid into the output once it frees up
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_trigger_pins = out_data_ff.trigger_pins;
   assign rsp_distance_a   = out_data_ff.distances[0];
   assign rsp_distance_b   = out_data_ff.distances[1];
   assign rsp_distance_c   = out_data_ff.distances[2];
   assign rsp_distance_d   = out_data_ff.distances[3];
   assign rsp_round_done   = out_data_ff.round_done;
   assign rsp_busy_res     = out_data_ff.busy_res;

endmodule

FILE: hdl/uer4_checker.sv
module uer4_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_trigger_pins,
   input logic       rsp_round_done,
   input logic       rsp_busy_res
);

   // a held rsp beat stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // req only backs up once the output side holds a beat
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req stalled with empty output");

   // at most one sensor triggered, and only inside a round
   a_trig_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_trigger_pins) && (rsp_trigger_pins == 4'd0 || rsp_busy_res))
      else $error("bad trigger drive");

   // a round can only end on a tick that started busy
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_round_done |-> rsp_busy_res)
      else $error("round_done outside a round");

   // output empty the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind ultrasonic_echo_ranger_four_channel_top uer4_checker u_uer4_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_trigger_pins (rsp_trigger_pins),
   .rsp_round_done   (rsp_round_done),
   .rsp_busy_res     (rsp_busy_res)
);

FILE: tb/sv/tb_ultrasonic_echo_ranger_four_channel_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the four-channel echo ranger. Every req beat is one
// 1 us tick. A scoreboard class predicts the rsp beat that each tick causes.
// A small echo generator in the bench answers each trigger the way a sensor
// would: a delay, then a high pulse. Some pulses are made to be silent, already
// high during the trigger, noisy, or to end exactly on the last allowed tick.
module tb_ultrasonic_echo_ranger_four_channel_top;
   import uer4_pkg::*;

   // ------------------------------------------------------------------
   // DUT signals, all inputs known from time zero
   // ------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_start_round = 1'b0;
   logic [3:0]  req_echo_levels = 4'b0000;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_trigger_pins;
   logic [9:0]  rsp_distance_a;
   logic [9:0]  rsp_distance_b;
   logic [9:0]  rsp_distance_c;
   logic [9:0]  rsp_distance_d;
   logic        rsp_round_done;
   logic        rsp_busy_res;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'h0;
   logic [31:0] csr_pwdata = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ultrasonic_echo_ranger_four_channel_top uut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Scoreboard: tick-level predictor plus the queue of expected beats
   // ------------------------------------------------------------------
   class ranging_scoreboard;
      logic [7:0]  trig_len;
      logic [14:0] wait_limit;
      logic [15:0] settle_len;
      phase_type   phase;
      logic [1:0]  sensor;
      logic [15:0] tick_cnt;
      logic [5:0]  sub_cnt;
      logic [9:0]  accum;
      logic        prev_echo;
      logic [9:0]  stored_dist [4];
      rsp_type     expected_beats [$];
      int          errors;
      int          compared;
      int          ticks;
      int          rounds;
      int          echoes_measured;
      int          echo_timeouts;

      function new();
         trig_len = TriggerTicksReset;
         wait_limit = TimeoutTicksReset;
         settle_len = SettleTicksReset;
         phase = PH_IDLE;
         sensor = 2'd0;
         tick_cnt = 16'd0;
         sub_cnt = 6'd0;
         accum = 10'd0;
         prev_echo = 1'b0;
         foreach (stored_dist[i]) stored_dist[i] = 10'd0;
         errors = 0;
         compared = 0;
         ticks = 0;
         rounds = 0;
         echoes_measured = 0;
         echo_timeouts = 0;
      endfunction

      // upper value bits beyond each register are dropped
      function void write_reg(reg_index_type idx, logic [31:0] value);
         case (idx)
            REG_TRIGGER: trig_len = value[7:0];
            REG_TIMEOUT: wait_limit = value[14:0];
            REG_SETTLE:  settle_len = value[15:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(reg_index_type idx);
         case (idx)
            REG_TRIGGER: return 32'(trig_len);
            REG_TIMEOUT: return 32'(wait_limit);
            REG_SETTLE:  return 32'(settle_len);
            default:     return 32'h0;
         endcase
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      // next sensor, or back to idle; returns 1 when the round is over
      function logic advance_sensor();
         tick_cnt = 16'd0;
         if (int'(sensor) + 1 >= NumSensors) begin
            phase = PH_IDLE;
            sensor = 2'd0;
            return 1'b1;
         end
         sensor = sensor + 2'd1;
         phase = PH_TRIG;
         return 1'b0;
      endfunction

      function void note_tick(logic start, logic [3:0] echoes);
         rsp_type want;
         logic    echo;
         logic    finished;
         echo = echoes[sensor];
         // trigger and busy reflect the phase at the start of the tick
         want.trigger_pins = (phase == PH_TRIG) ? (4'b0001 << sensor) : 4'b0000;
         want.busy_res = (phase != PH_IDLE);
         want.round_done = 1'b0;
         finished = 1'b0;
         ticks++;
         case (phase)
            PH_IDLE: begin
               if (start) begin
                  phase = PH_TRIG;
                  sensor = 2'd0;
                  tick_cnt = 16'd0;
                  rounds++;
               end
            end
            PH_TRIG: begin
               prev_echo = echo;
               tick_cnt = tick_cnt + 16'd1;
               if (tick_cnt >= 16'(trig_len)) begin
                  phase = PH_RISE;
                  tick_cnt = 16'd0;
               end
            end
            PH_RISE, PH_FALL: begin
               tick_cnt = tick_cnt + 16'd1;
               if (phase == PH_RISE) begin
                  if (echo && !prev_echo) begin
                     phase = PH_FALL;
                     accum = 10'd0;
                     sub_cnt = 6'd1;
                  end
               end else if (echo) begin
                  sub_cnt = sub_cnt + 6'd1;
                  if (sub_cnt >= CmDivisor) begin
                     sub_cnt = 6'd0;
                     if (accum < DistMax) accum = accum + 10'd1;
                  end
               end else begin
                  stored_dist[sensor] = accum;
                  finished = 1'b1;
                  echoes_measured++;
                  if (settle_len == 16'd0) begin
                     want.round_done = advance_sensor();
                  end else begin
                     phase = PH_SETTLE;
                     tick_cnt = 16'd0;
                  end
               end
               prev_echo = echo;
               // a fall on the last allowed tick already counted as success
               if (!finished && tick_cnt >= 16'(wait_limit)) begin
                  stored_dist[sensor] = 10'd0;
                  echo_timeouts++;
                  want.round_done = advance_sensor();
               end
            end
            PH_SETTLE: begin
               tick_cnt = tick_cnt + 16'd1;
               if (tick_cnt >= settle_len) want.round_done = advance_sensor();
            end
            default: begin
               phase = PH_IDLE;
               sensor = 2'd0;
               tick_cnt = 16'd0;
            end
         endcase
         for (int i = 0; i < 4; i++) want.distances[i] = stored_dist[i];
         expected_beats.push_back(want);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40) $display("MISMATCH: %s", msg);
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_beats.size() == 0) begin
            report("rsp beat arrived with no tick pending");
         end else begin
            want = expected_beats.pop_front();
            compared++;
            if (got.trigger_pins !== want.trigger_pins)
               report($sformatf("beat %0d trigger_pins: got %b, want %b",
                                compared, got.trigger_pins, want.trigger_pins));
            for (int i = 0; i < 4; i++) begin
               if (got.distances[i] !== want.distances[i])
                  report($sformatf("beat %0d distance of sensor %0d: got %0d, want %0d",
                                   compared, i, got.distances[i], want.distances[i]));
            end
            if (got.round_done !== want.round_done)
               report($sformatf("beat %0d round_done: got %b, want %b",
                                compared, got.round_done, want.round_done));
            if (got.busy_res !== want.busy_res)
               report($sformatf("beat %0d busy_res: got %b, want %b",
                                compared, got.busy_res, want.busy_res));
         end
      endtask
   endclass

   ranging_scoreboard sb = new();

   // ------------------------------------------------------------------
   // Echo generator. Times count from the end of the trigger, in ticks,
   // which is exactly the predictor's tick_cnt during the echo wait.
   //   pre_high: echo already high during and after the trigger
   //   delay/width: the echo pulse proper
   //   noisy: random level on every tick
   // ------------------------------------------------------------------
   typedef struct packed {
      int pre_high;
      int delay;
      int width;
      bit noisy;
   } echo_shape_type;

   echo_shape_type shape;
   bit             shape_armed = 1'b0;
   echo_shape_type shape_q [$];      // directed shapes, one per sensor, in order
   bit             quiet = 1'b0;     // no idling on either side
   int             csr_writes = 0;
   rsp_type        rsp_beat;

   function automatic echo_shape_type mk_shape(int pre, int dly, int w, bit noisy);
      echo_shape_type s;
      s.pre_high = pre;
      s.delay = dly;
      s.width = w;
      s.noisy = noisy;
      return s;
   endfunction

   function automatic echo_shape_type random_shape();
      echo_shape_type s;
      int             t;
      int             kind;
      t = int'(sb.wait_limit);
      kind = $urandom_range(0, 9);
      s = mk_shape(0, $urandom_range(0, t + 5), $urandom_range(1, 400), 1'b0);
      case (kind)
         5: s.width = 58 * $urandom_range(1, 6) + $urandom_range(0, 2) - 1;
         6: s.delay = t + 10;                          // never answers
         7: begin                                      // high before trigger ends
            s.pre_high = $urandom_range(1, 30);
            s.delay = s.pre_high + $urandom_range(0, 8);
         end
         8: s.noisy = 1'b1;
         9: begin                                      // fall on the last tick
            if (t >= 3) begin
               s.width = $urandom_range(1, (t - 2 < 180) ? t - 2 : 180);
               s.delay = t - 1 - s.width;
            end
         end
         default: ;
      endcase
      return s;
   endfunction

   // echo pins for the tick about to be sent; other sensors get noise
   function automatic logic [3:0] next_echo_levels();
      logic [3:0] lv;
      int         k;
      lv = 4'($urandom);
      k = int'(sb.tick_cnt);
      case (sb.phase)
         PH_TRIG:
            lv[sb.sensor] = shape.noisy ? 1'($urandom) : (shape.pre_high > 0);
         PH_RISE, PH_FALL:
            lv[sb.sensor] = shape.noisy ? 1'($urandom) :
                            (k < shape.pre_high) ||
                            (k >= shape.delay && k < shape.delay + shape.width);
         default: ;
      endcase
      return lv;
   endfunction

   // ------------------------------------------------------------------
   // req side driver
   // ------------------------------------------------------------------
   task send_tick(bit start);
      logic [3:0] lv;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      // a new sensor starts its trigger: pick how it will answer
      if (sb.phase == PH_TRIG) begin
         if (!shape_armed) begin
            if (shape_q.size() != 0) shape = shape_q.pop_front();
            else shape = random_shape();
            shape_armed = 1'b1;
         end
      end else begin
         shape_armed = 1'b0;
      end
      lv = next_echo_levels();
      req_valid <= 1'b1;
      req_start_round <= start;
      req_echo_levels <= lv;
      // the beat is taken at the first edge with stall low
      do @(posedge clock); while (req_stall);
      sb.note_tick(start, lv);
   endtask

   task idle_ticks(int n);
      repeat (n) send_tick(1'b0);
   endtask

   // start a round and tick until it ends; hold_start keeps start high
   // so that requests while busy are seen and ignored
   task run_round(bit hold_start);
      send_tick(1'b1);
      while (sb.phase != PH_IDLE) send_tick(hold_start ? 1'b1 : 1'($urandom));
   endtask

   // stop ticking and let every expected beat come back
   task drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // register port
   // ------------------------------------------------------------------
   task csr_read_check(reg_index_type idx);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== sb.reg_value(idx))
         sb.report($sformatf("register %s reads %h, want %h",
                             idx.name(), csr_prdata, sb.reg_value(idx)));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      // the port goes idle between transfers
      @(posedge clock);
   endtask

   task csr_write(reg_index_type idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, value);
      csr_writes++;
      csr_read_check(idx);
   endtask

   // junk in the bits above each field must be dropped
   task set_timing(int trig, int tmo, int settle);
      logic [31:0] junk;
      junk = $urandom;
      csr_write(REG_TRIGGER, {junk[31:8], 8'(trig)});
      junk = $urandom;
      csr_write(REG_TIMEOUT, {junk[31:15], 15'(tmo)});
      junk = $urandom;
      csr_write(REG_SETTLE, {junk[31:16], 16'(settle)});
   endtask

   // one random timing setting, then random rounds for about budget ticks
   task random_phase(int budget);
      int trig;
      int tmo;
      int settle;
      int stop_at;
      trig = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
      tmo = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : $urandom_range(20, 100);
      settle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      drain();
      set_timing(trig, tmo, settle);
      stop_at = sb.ticks + budget;
      while (sb.ticks < stop_at) begin
         idle_ticks($urandom_range(0, 4));
         run_round(1'b0);
      end
   endtask

   // ------------------------------------------------------------------
   // rsp side: random stall bursts, and the monitor
   // ------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && !quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_beat.trigger_pins = rsp_trigger_pins;
         rsp_beat.distances[0] = rsp_distance_a;
         rsp_beat.distances[1] = rsp_distance_b;
         rsp_beat.distances[2] = rsp_distance_c;
         rsp_beat.distances[3] = rsp_distance_d;
         rsp_beat.round_done = rsp_round_done;
         rsp_beat.busy_res = rsp_busy_res;
         sb.check_result(rsp_beat);
      end
   end

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers come out of reset at their defaults
      csr_read_check(REG_TRIGGER);
      csr_read_check(REG_TIMEOUT);
      csr_read_check(REG_SETTLE);

      // ticks with no start are ignored, outputs stay at zero
      idle_ticks(5);
      drain();

      // one of each answer: normal 1 cm, silent, high through the trigger
      // (must fall and rise again), and a fall on the last allowed tick;
      // start is held high the whole round
      set_timing(3, 200, 4);
      shape_q.push_back(mk_shape(0, 5, 59, 1'b0));
      shape_q.push_back(mk_shape(0, 400, 0, 1'b0));
      shape_q.push_back(mk_shape(8, 12, 130, 1'b0));
      shape_q.push_back(mk_shape(0, 83, 116, 1'b0));
      run_round(1'b1);
      drain();

      // zero trigger and timeout both act as one tick: every sensor times out
      set_timing(0, 0, 0);
      repeat (4) shape_q.push_back(mk_shape(0, 0, 5, 1'b0));
      run_round(1'b0);
      drain();

      // timeout two: a one-tick pulse falls on the last tick, 0 cm,
      // and with no settle time the next sensor follows at once
      set_timing(1, 2, 0);
      repeat (4) shape_q.push_back(mk_shape(0, 0, 1, 1'b0));
      run_round(1'b0);
      drain();

      // widths on both sides of the 58-tick boundaries
      set_timing(2, 150, 0);
      shape_q.push_back(mk_shape(0, 3, 57, 1'b0));
      shape_q.push_back(mk_shape(0, 3, 58, 1'b0));
      shape_q.push_back(mk_shape(0, 3, 115, 1'b0));
      shape_q.push_back(mk_shape(0, 3, 116, 1'b0));
      run_round(1'b0);
      drain();

      // largest settings are written and read back; a round at these
      // lengths would run far longer than the rest of the test
      set_timing(255, 32767, 65535);

      // random timing and random sensor answers; the last stretch
      // runs at full rate on both sides
      for (int p = 0; p < 3; p++) begin
         if (p == 2) quiet = 1'b1;
         random_phase(100);
      end

      req_valid <= 1'b0;
      for (int c = 0; c < 200 && sb.pending() != 0; c++) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected beats never arrived", sb.pending()));
      repeat (10) @(posedge clock);

      $display("Covered %0d rounds over %0d ticks: %0d echoes measured, %0d timeouts",
               sb.rounds, sb.ticks, sb.echoes_measured, sb.echo_timeouts);
      $display("Compared %0d result beats; %0d register writes, each read back",
               sb.compared, csr_writes);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // hard limit, several times the slowest legal run
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
